// ----- design/sccit_pkg.sv -----
// Shared widths, status codes and cell payload types for the swept circle
// impact time block. No dependencies.
package sccit_pkg;

  localparam int unsigned CW  = 32;         // coordinate width
  localparam int unsigned DFW = CW + 1;     // coordinate difference width
  localparam int unsigned MGW = CW;         // magnitude of a difference
  localparam int unsigned PW  = 2 * MGW;    // one magnitude product
  localparam int unsigned AW  = PW + 1;     // a, c, |h|, e.e
  localparam int unsigned DW  = 2 * AW;     // discriminant
  localparam int unsigned RTW = AW;         // square root
  localparam int unsigned RW  = RTW + 2;    // square root partial remainder
  localparam int unsigned OTW = 17;         // impact_time port width

  typedef enum logic [1:0] {
    ST_CALC,
    ST_OVERLAP,
    ST_MISS
  } status_e;

  // Payload of one square root cell
  typedef struct packed {
    status_e         st;
    logic [AW-1:0]   a;
    logic [AW-1:0]   hm;
    logic [DW-1:0]   x;
    logic [RW-1:0]   rem;
    logic [RTW-1:0]  root;
  } sq_t;

  // Payload of one divider cell
  typedef struct packed {
    status_e         st;
    logic [AW-1:0]   a;
    logic [AW:0]     rem;
  } dv_t;

endpackage

// ----- design/sccit_mul.sv -----
// Two stage wide unsigned multiplier built from four half-width products.
// No dependencies.
module sccit_mul #(
  parameter int unsigned W = 65
) (
  input  logic           clk_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] p_o
);
  localparam int unsigned LO = (W + 1) / 2;
  localparam int unsigned HI = W - LO;

  logic [2*LO-1:0]   ll_q;
  logic [LO+HI-1:0]  lh_q, hl_q;
  logic [2*HI-1:0]   hh_q;
  logic [2*W-1:0]    p_d, p_q;

  always_ff @(posedge clk_i) begin
    ll_q <= a_i[LO-1:0] * b_i[LO-1:0];
    lh_q <= (LO+HI)'(a_i[LO-1:0]) * (LO+HI)'(b_i[W-1:LO]);
    hl_q <= (LO+HI)'(a_i[W-1:LO]) * (LO+HI)'(b_i[LO-1:0]);
    hh_q <= a_i[W-1:LO] * b_i[W-1:LO];
  end

  // Sum the partial products at full width
  assign p_d = (2*W)'(ll_q) + ((2*W)'(lh_q) << LO) + ((2*W)'(hl_q) << LO)
             + ((2*W)'(hh_q) << (2*LO));

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ----- design/sccit_sqrt_cell.sv -----
// One cell of the integer square root chain: settles one root bit.
// Depends on sccit_pkg.
module sccit_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  sccit_pkg::sq_t d_i,
  output logic          vld_o,
  output sccit_pkg::sq_t q_o
);
  import sccit_pkg::*;

  logic [RW+1:0] cur, trial;
  logic          take;
  sq_t           d_d, d_q;
  logic          vld_q;

  always_comb begin
    cur   = {d_i.rem, d_i.x[DW-1:DW-2]};
    trial = (RW+2)'({d_i.root, 2'b01});
    take  = cur >= trial;
    d_d      = d_i;
    d_d.x    = {d_i.x[DW-3:0], 2'b00};
    d_d.rem  = take ? RW'(cur - trial) : RW'(cur);
    d_d.root = {d_i.root[RTW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
  end

  assign vld_o = vld_q;
  assign q_o   = d_q;

endmodule

// ----- design/sccit_div_cell.sv -----
// One cell of the restoring divider chain: settles one quotient bit.
// Depends on sccit_pkg.
module sccit_div_cell #(
  parameter int unsigned QW = 17
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  sccit_pkg::dv_t d_i,
  input  logic [QW-1:0]  quo_i,
  output logic           vld_o,
  output sccit_pkg::dv_t q_o,
  output logic [QW-1:0]  quo_o
);
  import sccit_pkg::*;

  logic          take;
  logic [AW:0]   r2;
  dv_t           d_d, d_q;
  logic [QW-1:0] quo_q;
  logic          vld_q;

  always_comb begin
    take    = d_i.rem >= (AW+1)'(d_i.a);
    r2      = take ? d_i.rem - (AW+1)'(d_i.a) : d_i.rem;
    d_d     = d_i;
    d_d.rem = {r2[AW-1:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    quo_q <= {quo_i[QW-2:0], take};
  end

  assign vld_o = vld_q;
  assign q_o   = d_q;
  assign quo_o = quo_q;

endmodule

// ----- design/swept_circle_circle_impact_time.sv -----
// Swept circle versus still circle, earliest time of contact in one step.
// Depends on sccit_pkg, sccit_mul, sccit_sqrt_cell and sccit_div_cell.
//
// The block takes one pair on every clock cycle (busy_o stays low) and
// returns one result per pair, in order. The result is shown for one
// cycle with done_o high and cannot be held off, so capture it then. The
// pipeline is made of the square root chain (65 cells, one root bit each)
// and the divider chain (TIME_FRAC_BITS + 1 cells), plus eight front and
// glue stages. hit_o is set when the circles overlap or touch at the
// start (time 0) or meet within the step; impact_time_o is then the
// truncated contact time with TIME_FRAC_BITS fraction bits, otherwise 0.
module swept_circle_circle_impact_time #(
  parameter int unsigned TIME_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] mover_start_x_i,
  input  logic [31:0] mover_start_y_i,
  input  logic [31:0] mover_end_x_i,
  input  logic [31:0] mover_end_y_i,
  input  logic [30:0] mover_radius_i,
  input  logic [31:0] target_x_i,
  input  logic [31:0] target_y_i,
  input  logic [30:0] target_radius_i,
  output logic        done_o,
  output logic        hit_o,
  output logic [16:0] impact_time_o
);
  import sccit_pkg::*;

  localparam int unsigned QW  = TIME_FRAC_BITS + 1;
  localparam int unsigned LAT = TIME_FRAC_BITS + 74;

  // ---------------- stage 1: differences and magnitudes ----------------
  logic [DFW-1:0] ex, ey, sx, sy;
  logic           v1_q;
  logic [MGW-1:0] mex_q, mey_q, msx_q, msy_q;
  logic           n1_q, n2_q;
  logic [CW-1:0]  rs_q;

  assign ex = {mover_start_x_i[31], mover_start_x_i} - {target_x_i[31], target_x_i};
  assign ey = {mover_start_y_i[31], mover_start_y_i} - {target_y_i[31], target_y_i};
  assign sx = {mover_end_x_i[31], mover_end_x_i} - {mover_start_x_i[31], mover_start_x_i};
  assign sy = {mover_end_y_i[31], mover_end_y_i} - {mover_start_y_i[31], mover_start_y_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    mex_q <= MGW'(ex[DFW-1] ? -ex : ex);
    mey_q <= MGW'(ey[DFW-1] ? -ey : ey);
    msx_q <= MGW'(sx[DFW-1] ? -sx : sx);
    msy_q <= MGW'(sy[DFW-1] ? -sy : sy);
    // sign of each term of e.s
    n1_q  <= ex[DFW-1] ^ sx[DFW-1];
    n2_q  <= ey[DFW-1] ^ sy[DFW-1];
    rs_q  <= {1'b0, mover_radius_i} + {1'b0, target_radius_i};
  end

  // ---------------- stage 2: products ----------------
  logic          v2_q, n1b_q, n2b_q;
  logic [PW-1:0] exx_q, eyy_q, sxx_q, syy_q, p1_q, p2_q, rr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    exx_q <= mex_q * mex_q;
    eyy_q <= mey_q * mey_q;
    sxx_q <= msx_q * msx_q;
    syy_q <= msy_q * msy_q;
    p1_q  <= mex_q * msx_q;
    p2_q  <= mey_q * msy_q;
    rr_q  <= rs_q * rs_q;
    n1b_q <= n1_q;
    n2b_q <= n2_q;
  end

  // ---------------- stage 3: a, c, h and early outcomes ----------------
  logic [AW-1:0]      ee, a3;
  logic signed [AW:0] t1, t2, hs;
  logic               v3_q;
  status_e            st3_d, st3_q;
  logic [AW-1:0]      a3_q, c3_q, hm3_q;

  always_comb begin
    ee = AW'(exx_q) + AW'(eyy_q);
    a3 = AW'(sxx_q) + AW'(syy_q);
    t1 = $signed({2'b00, p1_q});
    t2 = $signed({2'b00, p2_q});
    hs = (n1b_q ? -t1 : t1) + (n2b_q ? -t2 : t2);
    if (ee <= AW'(rr_q)) begin
      st3_d = ST_OVERLAP;
    end else if (a3 == '0 || !hs[AW]) begin
      // mover at rest, or moving away or parallel
      st3_d = ST_MISS;
    end else begin
      st3_d = ST_CALC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st3_q <= st3_d;
    a3_q  <= a3;
    c3_q  <= ee - AW'(rr_q);
    hm3_q <= AW'(hs[AW] ? -hs : hs);
  end

  // ---------------- stages 4 and 5: h*h and a*c ----------------
  logic [DW-1:0] hh, ac;
  logic          v4_q, v5_q;
  status_e       st4_q, st5_q;
  logic [AW-1:0] a4_q, a5_q, hm4_q, hm5_q;

  sccit_mul #(.W(AW)) u_mul_hh (.clk_i(clk_i), .a_i(hm3_q), .b_i(hm3_q), .p_o(hh));
  sccit_mul #(.W(AW)) u_mul_ac (.clk_i(clk_i), .a_i(a3_q), .b_i(c3_q), .p_o(ac));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Hold the item alongside the multipliers
  always_ff @(posedge clk_i) begin
    st4_q <= st3_q;
    st5_q <= st4_q;
    a4_q  <= a3_q;
    a5_q  <= a4_q;
    hm4_q <= hm3_q;
    hm5_q <= hm4_q;
  end

  // ---------------- stage 6: discriminant, square root chain ----------------
  logic sv [0:RTW];
  sq_t  sq [0:RTW];
  sq_t  sq0_d;

  always_comb begin
    sq0_d.st   = (st5_q == ST_CALC && hh < ac) ? ST_MISS : st5_q;
    sq0_d.a    = a5_q;
    sq0_d.hm   = hm5_q;
    sq0_d.x    = hh - ac;
    sq0_d.rem  = '0;
    sq0_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq[0] <= sq0_d;
  end

  for (genvar k = 0; k < RTW; k++) begin : g_sqrt
    sccit_sqrt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (sv[k]),
      .d_i   (sq[k]),
      .vld_o (sv[k+1]),
      .q_o   (sq[k+1])
    );
  end

  // ---------------- numerator and late-contact check ----------------
  logic          pv_q;
  status_e       pst_q;
  logic [AW-1:0] pa_q, pnum_q, num;

  assign num = sq[RTW].hm - sq[RTW].root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= sv[RTW];
    end
  end

  always_ff @(posedge clk_i) begin
    pst_q  <= (sq[RTW].st == ST_CALC && num > sq[RTW].a) ? ST_MISS : sq[RTW].st;
    pa_q   <= sq[RTW].a;
    pnum_q <= num;
  end

  // ---------------- divider chain ----------------
  logic          dvv [0:QW];
  dv_t           dv  [0:QW];
  logic [QW-1:0] quo [0:QW];

  assign dvv[0]    = pv_q;
  assign dv[0].st  = pst_q;
  assign dv[0].a   = pa_q;
  assign dv[0].rem = {1'b0, pnum_q};
  assign quo[0]    = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    sccit_div_cell #(.QW(QW)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (dvv[k]),
      .d_i   (dv[k]),
      .quo_i (quo[k]),
      .vld_o (dvv[k+1]),
      .q_o   (dv[k+1]),
      .quo_o (quo[k+1])
    );
  end

  // ---------------- result register ----------------
  logic           done_q, hit_q;
  logic [OTW-1:0] time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dvv[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= dv[QW].st == ST_OVERLAP || dv[QW].st == ST_CALC;
    time_q <= (dv[QW].st == ST_CALC) ? OTW'(quo[QW]) : '0;
  end

  assign busy_o        = 1'b0;
  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign impact_time_o = time_q;

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT done_o)
    else $error("result did not appear at the fixed latency");

  a_time_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && impact_time_o != '0 |-> hit_o)
    else $error("nonzero time without a hit");

  a_num_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q && pst_q == ST_CALC |-> pnum_q <= pa_q)
    else $error("divider entered with numerator above a");

endmodule

// ----- verif/tb_swept_circle_circle_impact_time.sv -----
// Testbench for swept_circle_circle_impact_time: directed contact cases, then random pairs.
// Depends on the block's RTL and sccit_pkg; expected results come from a built-in predictor.
`timescale 1ns / 100ps

module tb_swept_circle_circle_impact_time;
  import sccit_pkg::*;

  localparam int unsigned TFB = 16;           // time fraction bits
  localparam logic [31:0] ONE = 32'h0001_0000; // 1.0 in Q16.16

  // One pair of circles, as driven onto the ports
  typedef struct {
    logic [31:0] sx, sy, ex, ey;
    logic [30:0] mr;
    logic [31:0] tx, ty;
    logic [30:0] tr;
  } pair_t;

  // One contact result
  typedef struct {
    logic        hit;
    logic [16:0] t;
  } contact_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] mover_start_x_i = '0, mover_start_y_i = '0;
  logic [31:0] mover_end_x_i = '0, mover_end_y_i = '0;
  logic [30:0] mover_radius_i = '0, target_radius_i = '0;
  logic [31:0] target_x_i = '0, target_y_i = '0;
  logic        done_o, hit_o;
  logic [16:0] impact_time_o;

  contact_t contact_q[$];   // predicted contacts, oldest first
  int       n_errors = 0;
  int       gap_pct = 0;    // chance in a hundred that the sender idles, rolled again while idle

  always #5 clk_i = ~clk_i;

  swept_circle_circle_impact_time #(.TIME_FRAC_BITS(TFB)) u_top (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .mover_start_x_i, .mover_start_y_i, .mover_end_x_i, .mover_end_y_i,
    .mover_radius_i, .target_x_i, .target_y_i, .target_radius_i,
    .done_o, .hit_o, .impact_time_o
  );

  // Exact integer square root, truncated, by one result bit per step
  function automatic logic [191:0] isqrt_wide(logic [191:0] x);
    logic [191:0] num, res, bitv;
    num = x;
    res = '0;
    bitv = 192'd1 << 190;
    for (int k = 0; k < 96; k++) begin
      if (num >= res + bitv) begin
        num = num - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Earliest contact time in the step, from the half-b form of the quadratic
  function automatic contact_t impact_of(pair_t p);
    logic signed [191:0] exw, eyw, sxw, syw, h;
    logic [191:0] ee, rr, rsum, a, c, hm, hh, ac, dsc, num, q;
    contact_t r;
    r.hit = 1'b0;
    r.t = '0;
    exw = longint'($signed(p.sx)) - longint'($signed(p.tx));
    eyw = longint'($signed(p.sy)) - longint'($signed(p.ty));
    sxw = longint'($signed(p.ex)) - longint'($signed(p.sx));
    syw = longint'($signed(p.ey)) - longint'($signed(p.sy));
    ee = exw * exw + eyw * eyw;
    rsum = {161'd0, p.mr} + {161'd0, p.tr};
    rr = rsum * rsum;
    // Overlapping or touching at the start: contact at time zero
    if (ee <= rr) begin
      r.hit = 1'b1;
      return r;
    end
    c = ee - rr;
    a = sxw * sxw + syw * syw;
    if (a == 0) return r;          // mover at rest
    h = exw * sxw + eyw * syw;
    if (h >= 0) return r;          // moving away or parallel
    hm = -h;
    hh = hm * hm;
    ac = a * c;
    if (hh < ac) return r;         // path misses the target
    dsc = hh - ac;
    num = hm - isqrt_wide(dsc);
    if (num > a) return r;         // contact only after the step ends
    q = (num << TFB) / a;
    r.hit = 1'b1;
    r.t = q[16:0];
    return r;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $time, what);
    n_errors++;
  endtask

  // Drive one pair and hold it until the block takes the transfer
  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    mover_start_x_i <= p.sx;
    mover_start_y_i <= p.sy;
    mover_end_x_i <= p.ex;
    mover_end_y_i <= p.ey;
    mover_radius_i <= p.mr;
    target_x_i <= p.tx;
    target_y_i <= p.ty;
    target_radius_i <= p.tr;
    do @(posedge clk_i); while (busy_o);
    contact_q.push_back(impact_of(p));
  endtask

  function automatic pair_t mk(logic [31:0] sx, sy, ex, ey, logic [31:0] mr,
                               logic [31:0] tx, ty, logic [31:0] tr);
    pair_t p;
    p.sx = sx; p.sy = sy; p.ex = ex; p.ey = ey;
    p.mr = mr[30:0]; p.tx = tx; p.ty = ty; p.tr = tr[30:0];
    return p;
  endfunction

  // Check each result against the oldest prediction
  always @(posedge clk_i) begin
    contact_t want;
    if (rst_ni && done_o) begin
      if (contact_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = contact_q.pop_front();
        if (hit_o !== want.hit)
          report($sformatf("hit %b, expected %b", hit_o, want.hit));
        if (impact_time_o !== want.t)
          report($sformatf("impact_time %0d, expected %0d", impact_time_o, want.t));
      end
    end
  end

  // Overlap, touching at start, and a mover at rest both overlapping and apart
  task automatic test_start_cases();
    send_pair(mk('0, '0, 10 * ONE, '0, ONE, '0, '0, ONE));
    send_pair(mk(3 * ONE, '0, 9 * ONE, ONE, ONE, 5 * ONE, '0, ONE));
    send_pair(mk('0, '0, '0, '0, ONE, 5 * ONE, '0, ONE));
    send_pair(mk('0, '0, '0, '0, 3 * ONE, ONE, '0, '0));
  endtask

  // Mid-step hit, contact exactly at the end, late contact, moving away, miss
  task automatic test_sweeps();
    send_pair(mk('0, '0, 10 * ONE, '0, ONE, 5 * ONE, '0, ONE));
    send_pair(mk('0, '0, 3 * ONE, '0, ONE, 5 * ONE, '0, ONE));
    send_pair(mk('0, '0, 2 * ONE, '0, ONE, 5 * ONE, '0, ONE));
    send_pair(mk('0, '0, -5 * ONE, '0, ONE, 5 * ONE, '0, ONE));
    send_pair(mk('0, 10 * ONE, 10 * ONE, 10 * ONE, ONE, 5 * ONE, '0, ONE));
    send_pair(mk('0, 10 * ONE, '0, '0, '0, '0, -7 * ONE, '0));
    send_pair(mk(-9 * ONE, -9 * ONE, 9 * ONE, 9 * ONE, 1, 2, -3, 1));
  endtask

  // Field extremes: full-range sweeps, largest and smallest radii
  task automatic test_extremes();
    send_pair(mk(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                 '0, '0, '0, '0));
    send_pair(mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_pair(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                 '0, 32'h8000_0000, 32'h8000_0000, '0));
    send_pair(mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h0fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0fff_ffff));
    send_pair(mk('1, '1, '1, '1, '1, '1, '1, '1));
    send_pair(mk('0, '0, '0, '0, '0, '0, '0, '0));
  endtask

  // Random pairs: mostly a mover aimed near the target at a random scale,
  // the rest full-range noise
  task automatic test_random(int n_pairs, int pct);
    pair_t p;
    int    k;
    gap_pct = pct;
    for (int i = 0; i < n_pairs; i++) begin
      k = $urandom_range(30);
      p.tx = $urandom();
      p.ty = $urandom();
      p.mr = 31'($urandom());
      p.tr = 31'($urandom());
      if ($urandom_range(3) == 0) begin
        p.sx = $urandom(); p.sy = $urandom();
        p.ex = $urandom(); p.ey = $urandom();
      end else begin
        p.sx = p.tx + 32'($signed($urandom()) >>> (31 - k));
        p.sy = p.ty + 32'($signed($urandom()) >>> (31 - k));
        p.ex = p.tx + 32'($signed($urandom()) >>> (31 - k));
        p.ey = p.ty + 32'($signed($urandom()) >>> (31 - k));
        p.mr = p.mr >> (31 - $urandom_range(k));
        p.tr = p.tr >> (31 - $urandom_range(k));
        if ($urandom_range(4) == 0) begin
          p.ex = p.sx; p.ey = p.sy;  // mover at rest
        end
      end
      send_pair(p);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    gap_pct = 21;
    test_start_cases();
    test_sweeps();
    test_extremes();
    test_random(210, 21);
    test_random(210, 46);
    test_random(210, 0);
    @(negedge clk_i);
    start_i <= 1'b0;
    // Drain: wait for every predicted contact, then allow the pipeline depth
    while (contact_q.size() != 0) @(posedge clk_i);
    repeat (TFB + 100) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hold a hard stop far beyond the slowest legal run
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
